### rtl/dtb_pkg.sv
package dtb_pkg;

  // Character codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // Scan phase; code 3 is unused and acts like PHASE_REST
  typedef enum logic [1:0] {
    PHASE_SPACE  = 2'd0,
    PHASE_DIGITS = 2'd1,
    PHASE_REST   = 2'd2
  } phase_e;

  // One input item
  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [63:0] value_high;
    logic [63:0] value_low;
  } out_item_t;

  // Raw scan state handed from the scanner to the result stage
  typedef struct packed {
    logic        wide;
    logic        negative;
    logic [63:0] acc_high;
    logic [63:0] acc_low;
  } scan_res_t;

endpackage

### rtl/dtb_scan.sv
module dtb_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  dtb_pkg::in_item_t   item_i,
  input  logic                wide_i,
  output dtb_pkg::scan_res_t  res_o
);

  dtb_pkg::phase_e phase_q, phase_d;
  logic            neg_q, neg_d;
  logic [63:0]     acc_high_q, acc_low_q;
  logic [127:0]    acc, acc_d, acc_next10;
  logic [3:0]      digit;
  logic            is_blank, is_digit, is_minus;

  // Character classes
  assign is_blank = (item_i.text_char == dtb_pkg::CHAR_SPACE) ||
                    ((item_i.text_char >= dtb_pkg::CHAR_TAB) &&
                     (item_i.text_char <= dtb_pkg::CHAR_CR));
  assign is_digit = (item_i.text_char >= dtb_pkg::CHAR_ZERO) &&
                    (item_i.text_char <= dtb_pkg::CHAR_NINE);
  assign is_minus = !wide_i && (item_i.text_char == dtb_pkg::CHAR_MINUS);
  assign digit    = 4'(item_i.text_char - dtb_pkg::CHAR_ZERO);

  // acc * 10 + digit, wraps mod 2^128
  assign acc        = {acc_high_q, acc_low_q};
  assign acc_next10 = (acc << 3) + (acc << 1) + 128'(digit);

  // Next scan state
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc;
    unique case (phase_q)
      dtb_pkg::PHASE_SPACE: begin
        if (!is_blank) begin
          if (is_minus) begin
            neg_d   = 1'b1;
            phase_d = dtb_pkg::PHASE_DIGITS;
          end else if (is_digit) begin
            acc_d   = acc_next10;
            phase_d = dtb_pkg::PHASE_DIGITS;
          end else begin
            phase_d = dtb_pkg::PHASE_REST;
          end
        end
      end
      dtb_pkg::PHASE_DIGITS: begin
        if (is_digit) acc_d = acc_next10;
        else          phase_d = dtb_pkg::PHASE_REST;
      end
      default: ;
    endcase
  end

  // Result as seen after this item
  assign res_o.wide     = wide_i;
  assign res_o.negative = neg_d;
  assign res_o.acc_high = acc_d[127:64];
  assign res_o.acc_low  = acc_d[63:0];

  // State registers; the last item of a string returns to start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= dtb_pkg::PHASE_SPACE;
      neg_q      <= 1'b0;
      acc_high_q <= '0;
      acc_low_q  <= '0;
    end else if (step_i) begin
      if (item_i.last_char) begin
        phase_q    <= dtb_pkg::PHASE_SPACE;
        neg_q      <= 1'b0;
        acc_high_q <= '0;
        acc_low_q  <= '0;
      end else begin
        phase_q    <= phase_d;
        neg_q      <= neg_d;
        acc_high_q <= acc_d[127:64];
        acc_low_q  <= acc_d[63:0];
      end
    end
  end

endmodule

### rtl/dtb_out_stage.sv
module dtb_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  dtb_pkg::scan_res_t  res_i,
  input  logic                ready_i,
  output logic                free_o,
  output logic                valid_o,
  output dtb_pkg::out_item_t  item_o
);

  logic               valid_q;
  dtb_pkg::scan_res_t res_q;

  assign free_o = !valid_q || ready_i;

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) res_q <= res_i;
  end

  // Format: signed mode negates on a leading minus, high word zero
  assign valid_o           = valid_q;
  assign item_o.value_high = res_q.wide ? res_q.acc_high : 64'd0;
  assign item_o.value_low  = (!res_q.wide && res_q.negative) ? (64'd0 - res_q.acc_low)
                                                             : res_q.acc_low;

endmodule

### rtl/decimal_text_to_binary_core.sv
// Decimal text to binary converter.
// Input channel in_valid_i/in_ready_o/in_item_i carries one text byte per
// item, with last_char set on the final byte of a token string. Leading
// whitespace is skipped, an optional minus is taken in signed mode, then
// digits accumulate until the first non-digit. The last byte of a string
// yields one result item on out_valid_o/out_ready_i/out_item_o; other
// bytes yield none.
// cfg_we_i/cfg_wdata_i write the mode bit (0 = signed 64-bit, 1 = unsigned
// 128-bit); write it only while no string is in flight.
// A result passes the input register, then the result register, before it
// is valid and can leave. Throughput: one byte per cycle while no last byte
// waits on a stalled result, set by the combinational times-ten update of
// the 128-bit accumulator.
// Reset clears the mode to signed, the scan state and the valid flags of both registers.
// When the receiver stalls, the result holds; non-final bytes keep flowing,
// and the next last byte waits in the input register, dropping in_ready_o.
module decimal_text_to_binary_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dtb_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dtb_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i
);

  logic               wide_q;
  logic               in_valid_q, in_valid_d;
  dtb_pkg::in_item_t  in_item_q;
  logic               step, out_free, in_accept;
  dtb_pkg::scan_res_t res;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wide_q <= 1'b0;
    else if (cfg_we_i) wide_q <= cfg_wdata_i;
  end

  // Input register; a last byte waits until the result register is free
  assign step       = in_valid_q && (!in_item_q.last_char || out_free);
  assign in_ready_o = !in_valid_q || step;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) in_valid_d = 1'b1;
    else if (step) in_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_valid_q <= 1'b0;
    else         in_valid_q <= in_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) in_item_q <= in_item_i;
  end

  dtb_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .wide_i (wide_q),
    .res_o  (res)
  );

  dtb_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && in_item_q.last_char),
    .res_i   (res),
    .ready_i (out_ready_i),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .item_o  (out_item_o)
  );

endmodule

### rtl/dtb_checker.sv
module dtb_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input dtb_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input dtb_pkg::out_item_t out_item_o,
  input logic               cfg_we_i,
  input logic               cfg_wdata_i
);

  logic mode_q;

  // Shadow of the mode bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= 1'b0;
    else if (cfg_we_i) mode_q <= cfg_wdata_i;
  end

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // Input only backs up behind a stalled result
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // A new result follows an accepted last byte through the input and result registers
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && in_item_i.last_char, 2))
    else $error("result without a final byte");

  // Signed mode leaves the high word zero
  a_signed_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mode_q |-> out_item_o.value_high == 64'd0)
    else $error("nonzero high word in signed mode");

endmodule

bind decimal_text_to_binary_core dtb_checker u_dtb_checker (.*);

### tb/sv/decimal_text_to_binary_core_test.sv
module decimal_text_to_binary_core_test;

  typedef logic [7:0] text_t[$];

  // Cycles with no accepted item before the run is abandoned
  localparam int STALL_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  dtb_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  dtb_pkg::out_item_t out_item;
  logic               cfg_we = 1'b0;
  logic               cfg_wdata = 1'b0;

  // Predictor state: mode bit, scan phase, sign flag and 128-bit accumulator
  logic            wide_m = 1'b0;
  dtb_pkg::phase_e phase_m = dtb_pkg::PHASE_SPACE;
  logic            neg_m = 1'b0;
  logic [127:0]    acc_m = '0;

  dtb_pkg::out_item_t expected_values[$];
  dtb_pkg::out_item_t want_item;
  bit        no_idle = 1'b0;
  int        errors = 0;
  int        bytes_sent = 0;
  int        strings_sent = 0;
  int        results_seen = 0;
  int        quiet_cycles = 0;

  decimal_text_to_binary_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Advance the converter state by one byte; queue a value on the last byte
  function automatic void predict_char(input logic [7:0] c, input logic last);
    bit                 digit;
    bit                 blank;
    dtb_pkg::out_item_t val;
    digit = (c >= dtb_pkg::CHAR_ZERO) && (c <= dtb_pkg::CHAR_NINE);
    blank = (c == dtb_pkg::CHAR_SPACE) ||
            ((c >= dtb_pkg::CHAR_TAB) && (c <= dtb_pkg::CHAR_CR));
    case (phase_m)
      dtb_pkg::PHASE_SPACE: begin
        if (!blank) begin
          if (!wide_m && c == dtb_pkg::CHAR_MINUS) begin
            neg_m   = 1'b1;
            phase_m = dtb_pkg::PHASE_DIGITS;
          end else if (digit) begin
            acc_m   = acc_m * 10 + (c - dtb_pkg::CHAR_ZERO);
            phase_m = dtb_pkg::PHASE_DIGITS;
          end else begin
            phase_m = dtb_pkg::PHASE_REST;
          end
        end
      end
      dtb_pkg::PHASE_DIGITS: begin
        if (digit) acc_m = acc_m * 10 + (c - dtb_pkg::CHAR_ZERO);
        else phase_m = dtb_pkg::PHASE_REST;
      end
      default: ;
    endcase
    if (last) begin
      if (wide_m) begin
        val.value_high = acc_m[127:64];
        val.value_low  = acc_m[63:0];
      end else begin
        val.value_high = '0;
        val.value_low  = neg_m ? -acc_m[63:0] : acc_m[63:0];
      end
      expected_values.push_back(val);
      phase_m = dtb_pkg::PHASE_SPACE;
      neg_m   = 1'b0;
      acc_m   = '0;
    end
  endfunction

  function automatic text_t to_text(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  // Mostly well-formed tokens with random content, some noise and junk tails
  function automatic text_t random_text();
    text_t t;
    int    kind;
    int    r;
    int    n;
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(255)));
      return t;
    end
    repeat ($urandom_range(0, 3)) begin
      r = $urandom_range(0, 5);
      t.push_back(r == 5 ? dtb_pkg::CHAR_SPACE : 8'(dtb_pkg::CHAR_TAB + r));
    end
    if ($urandom_range(99) < 30) t.push_back(dtb_pkg::CHAR_MINUS);
    r = $urandom_range(99);
    if (r < 5) n = 0;
    else if (r < 70) n = $urandom_range(1, 8);
    else if (r < 85) n = $urandom_range(9, 19);
    else if (r < 95) n = $urandom_range(18, 24);
    else n = $urandom_range(30, 45);
    repeat (n) t.push_back(8'(dtb_pkg::CHAR_ZERO + $urandom_range(9)));
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 3)) t.push_back(8'($urandom_range(255)));
    end
    // a string needs at least one byte to carry the last mark
    if (t.size() == 0) t.push_back(dtb_pkg::CHAR_SPACE);
    return t;
  endfunction

  // Offer one byte, hold it until accepted, then predict
  task automatic send_char(input logic [7:0] c, input logic last);
    // idle cycles at random, about one in five
    while (!no_idle && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{text_char: c, last_char: last};
    do @(posedge clk); while (!in_ready);
    predict_char(c, last);
    bytes_sent++;
  endtask

  task automatic send_text(input text_t t);
    foreach (t[i]) send_char(t[i], i == t.size() - 1);
    strings_sent++;
  endtask

  // Mode writes happen only with no string in flight and all results drained
  task automatic set_mode(input logic wide);
    in_valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= wide;
    @(posedge clk);
    cfg_we <= 1'b0;
    wide_m = wide;
  endtask

  task automatic test_signed_directed();
    text_t t;
    set_mode(1'b0);
    // every whitespace code, then a minus and a digit
    t = {8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d, dtb_pkg::CHAR_SPACE, dtb_pkg::CHAR_MINUS,
         dtb_pkg::CHAR_ZERO + 8'd7};
    send_text(t);
    send_text(to_text("-"));
    send_text(to_text(" "));
    send_text(to_text("12a3"));
    send_text(to_text("9:5"));
    send_text(to_text("/4"));
    send_text(to_text("+5"));
    send_text(to_text("5-"));
    t = {8'hff};
    send_text(t);
    t = {8'h00};
    send_text(t);
    // wraps modulo 2^64, then negated
    send_text(to_text("-99999999999999999999"));
  endtask

  task automatic test_unsigned_directed();
    set_mode(1'b1);
    // minus is just a non-digit here
    send_text(to_text("-5"));
    send_text(to_text(" 18446744073709551616"));
    send_text(to_text("340282366920938463463374607431768211457"));
  endtask

  task automatic test_random(input logic wide, input int count);
    int start;
    set_mode(wide);
    start = bytes_sent;
    while (bytes_sent - start < count) send_text(random_text());
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random(1'b1, 300);
    set_mode(1'b0);
    no_idle = 1'b0;
  endtask

  // Receiver stalls at random unless idling is off
  always @(posedge clk) begin
    out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 20);
  end

  // Compare each result with the oldest predicted value
  always @(posedge clk) begin
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected result high %h low %h", $time,
                 out_item.value_high, out_item.value_low);
        errors++;
      end else begin
        want_item = expected_values.pop_front();
        if (out_item.value_high !== want_item.value_high) begin
          $display("%0t: value_high expected %h actual %h", $time,
                   want_item.value_high, out_item.value_high);
          errors++;
        end
        if (out_item.value_low !== want_item.value_low) begin
          $display("%0t: value_low expected %h actual %h", $time,
                   want_item.value_low, out_item.value_low);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("decimal_text_to_binary_core: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_signed_directed();
    test_unsigned_directed();
    test_random(1'b0, 450);
    test_random(1'b1, 450);
    test_back_to_back();
    test_random(1'b0, 150);

    // drain
    in_valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Converted %0d strings (%0d bytes), %0d results checked", strings_sent,
             bytes_sent, results_seen);
    $display("Signed and unsigned modes, wraparound, noise, with and without stalls");
    if (errors == 0) begin
      $display("decimal_text_to_binary_core: match");
    end else begin
      $display("decimal_text_to_binary_core: mismatch");
    end
    $finish;
  end

endmodule
